// ===== rtl/core/multi_slot_software_timer_assert.svh =====
// Assertion macros shared by the timer bank's checker.
`ifndef MULTI_SLOT_SOFTWARE_TIMER_ASSERT_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define MSST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define MSST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/msst_pkg.sv =====
// Package with the shared types and constants of the timer bank.
`default_nettype none

package msst_pkg;

    localparam int TIME_W    = 32;
    localparam int SLOT_W    = 4;
    localparam int MAX_FIRES = 16;
    localparam int CNT_W     = $clog2(MAX_FIRES + 1);

    // Item mode codes.
    localparam logic [1:0] MODE_SERVICE = 2'd0;
    localparam logic [1:0] MODE_ARM     = 2'd1;
    localparam logic [1:0] MODE_DISARM  = 2'd2;

    // One stored slot: period, repeat flag and deadline.
    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic              rep_en;
        logic [TIME_W-1:0] deadline;
    } slot_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic arm;
        logic disarm;
        logic capture;
        logic issue;
        logic flush;
    } msst_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/msst_ctrl.sv =====
// Controller of the timer bank: accepts words and sequences the slot scan.
`default_nettype none

module msst_ctrl #(
    parameter  int NUM_SLOTS = 16,
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [1:0]           mode,
    output logic                      busy,
    output msst_pkg::msst_cmd_t       cmd,
    output logic [IDX_W-1:0]          rd_addr
);
    import msst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FLUSH
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              accept;

    // A word is taken only while no scan is running.
    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Commands to the datapath.
    always_comb
    begin
        cmd.arm     = accept && (mode == MODE_ARM);
        cmd.disarm  = accept && (mode == MODE_DISARM);
        cmd.capture = accept && (mode == MODE_SERVICE);
        cmd.issue   = (state_reg == S_SCAN);
        cmd.flush   = (state_reg == S_FLUSH);
    end

    assign rd_addr = idx_reg;

    // Scan sequencing: one slot read per cycle, then drain and flush.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == IDX_W'(NUM_SLOTS - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/msst_datapath.sv =====
// Datapath of the timer bank: slot memory, active bits, deadline test and fire output.
`default_nettype none

module msst_datapath #(
    parameter  int NUM_SLOTS = 16,
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire msst_pkg::msst_cmd_t           cmd,
    input  wire logic [IDX_W-1:0]              rd_addr,
    input  wire logic [msst_pkg::SLOT_W-1:0]   slot,
    input  wire logic [msst_pkg::TIME_W-1:0]   period_ms,
    input  wire logic                          repeat_flag,
    input  wire logic [msst_pkg::TIME_W-1:0]   now_ms,
    output logic                               fire,
    output logic [msst_pkg::SLOT_W-1:0]        fired_slot,
    output logic                               rearmed,
    output logic                               last
);
    import msst_pkg::*;

    slot_entry_t        mem [NUM_SLOTS];
    slot_entry_t        rd_data_reg;
    slot_entry_t        wr_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;

    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] active_next;
    logic                 eval_valid_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [CNT_W-1:0]     fire_cnt_reg;
    logic [CNT_W-1:0]     fire_cnt_next;

    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [IDX_W-1:0]   pend_slot_reg;
    logic [IDX_W-1:0]   pend_slot_next;
    logic               pend_rearm_reg;
    logic               pend_rearm_next;

    logic               fire_reg;
    logic               fire_next;
    logic [SLOT_W-1:0]  fired_slot_reg;
    logic [SLOT_W-1:0]  fired_slot_next;
    logic               rearmed_reg;
    logic               rearmed_next;
    logic               last_reg;
    logic               last_next;

    logic               slot_ok;
    logic [IDX_W-1:0]   cfg_addr;
    logic [TIME_W-1:0]  arm_period;
    logic [TIME_W-1:0]  diff;
    logic [TIME_W-1:0]  rearm_deadline;
    logic               due;

    // Arm and disarm decode; a slot beyond the bank is ignored.
    assign slot_ok    = (32'(slot) < 32'(NUM_SLOTS));
    assign cfg_addr   = IDX_W'(slot);
    assign arm_period = (period_ms == '0) ? TIME_W'(1) : period_ms;

    // Deadline test on the slot read in the previous cycle.
    assign diff           = now_reg - rd_data_reg.deadline;
    assign rearm_deadline = now_reg + rd_data_reg.period;
    assign due            = eval_valid_reg && active_reg[eval_idx_reg] && !diff[TIME_W-1]
                            && (fire_cnt_reg < CNT_W'(MAX_FIRES));

    // Memory write: an arm loads the whole entry, a repeating fire reloads the deadline.
    always_comb
    begin
        wr_en   = (cmd.arm && slot_ok) || (due && rd_data_reg.rep_en);
        wr_addr = cmd.arm ? cfg_addr : eval_idx_reg;
        if (cmd.arm)
        begin
            wr_data.period   = arm_period;
            wr_data.rep_en   = repeat_flag;
            wr_data.deadline = now_ms + arm_period;
        end
        else
        begin
            wr_data.period   = rd_data_reg.period;
            wr_data.rep_en   = 1'b1;
            wr_data.deadline = rearm_deadline;
        end
    end

    // Active bits mark armed slots: set by an arm, cleared by a disarm or by the fire of a one-shot slot.
    always_comb
    begin
        active_next = active_reg;
        if (cmd.arm && slot_ok)
        begin
            active_next[cfg_addr] = 1'b1;
        end
        if (cmd.disarm && slot_ok)
        begin
            active_next[cfg_addr] = 1'b0;
        end
        if (due && !rd_data_reg.rep_en)
        begin
            active_next[eval_idx_reg] = 1'b0;
        end
    end

    // A fire is kept pending until the next due fire or the flush, so a scan's final word can carry last.
    always_comb
    begin
        fire_cnt_next   = fire_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_rearm_next = pend_rearm_reg;
        fire_next       = 1'b0;
        fired_slot_next = fired_slot_reg;
        rearmed_next    = rearmed_reg;
        last_next       = last_reg;
        if (cmd.capture)
        begin
            fire_cnt_next   = '0;
            pend_valid_next = 1'b0;
        end
        if (due)
        begin
            fire_cnt_next = fire_cnt_reg + 1'b1;
            if (pend_valid_reg)
            begin
                fire_next       = 1'b1;
                fired_slot_next = SLOT_W'(pend_slot_reg);
                rearmed_next    = pend_rearm_reg;
                last_next       = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = eval_idx_reg;
            pend_rearm_next = rd_data_reg.rep_en;
        end
        if (cmd.flush && pend_valid_reg)
        begin
            fire_next       = 1'b1;
            fired_slot_next = SLOT_W'(pend_slot_reg);
            rearmed_next    = pend_rearm_reg;
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // Slot memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg <= now_ms;
        end
        eval_idx_reg   <= rd_addr;
        pend_slot_reg  <= pend_slot_next;
        pend_rearm_reg <= pend_rearm_next;
        fired_slot_reg <= fired_slot_next;
        rearmed_reg    <= rearmed_next;
        last_reg       <= last_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            eval_valid_reg <= 1'b0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            fire_reg       <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            eval_valid_reg <= cmd.issue;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
            fire_reg       <= fire_next;
        end
    end

    assign fire       = fire_reg;
    assign fired_slot = fired_slot_reg;
    assign rearmed    = rearmed_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/multi_slot_software_timer.sv =====
// Arm and disarm words start no scan; busy stays low and the next word may follow at once.
// A service word scans one slot per cycle from the slot memory, then drains and flushes;
// busy is high throughout, and a new service word is taken only once busy is low again.
// Each fire word waits until the next due slot is found and is shown for one cycle; the
// last one appears in the first cycle after busy falls. The receiver cannot stall the block.
// Reset disarms every slot at once through the active bits; no clearing pass is needed.
`default_nettype none

module multi_slot_software_timer #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    mode,
    input  wire logic [msst_pkg::SLOT_W-1:0]   slot,
    input  wire logic [msst_pkg::TIME_W-1:0]   period_ms,
    input  wire logic                          repeat_flag,
    input  wire logic [msst_pkg::TIME_W-1:0]   now_ms,
    output logic                               fire,
    output logic [msst_pkg::SLOT_W-1:0]        fired_slot,
    output logic                               rearmed,
    output logic                               last
);
    import msst_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    msst_cmd_t         cmd;
    logic [IDX_W-1:0]  rd_addr;

    // Controller.
    msst_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .mode    (mode),
        .busy    (busy),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    // Datapath.
    msst_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .slot        (slot),
        .period_ms   (period_ms),
        .repeat_flag (repeat_flag),
        .now_ms      (now_ms),
        .fire        (fire),
        .fired_slot  (fired_slot),
        .rearmed     (rearmed),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/msst_checker.sv =====
// Port-level checker of the timer bank and its bind to the top level.
`default_nettype none
`include "multi_slot_software_timer_assert.svh"

module msst_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] mode,
    input wire logic       fire,
    input wire logic       last
);
    import msst_pkg::*;

    // A fire word seen after the scan has ended must close the list.
    `MSST_ASSERT_NOW(a_idle_fire_is_last, fire && !busy, last, "fire word after scan without last")

    // The final word of a list is never followed directly by another.
    `MSST_ASSERT_NEXT(a_gap_after_last, fire && last, !fire, "fire word straight after last")

    // A service word starts a scan.
    `MSST_ASSERT_NEXT(a_service_busy, start && !busy && (mode == MODE_SERVICE), busy,
        "service word did not start a scan")

    // Arm and disarm words finish at once and cause no fire word.
    `MSST_ASSERT_NEXT(a_cfg_quiet,
        start && !busy && ((mode == MODE_ARM) || (mode == MODE_DISARM)), !busy && !fire,
        "arm or disarm word kept the block busy or fired")

endmodule

bind multi_slot_software_timer msst_checker u_msst_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .mode  (mode),
    .fire  (fire),
    .last  (last)
);

`default_nettype wire
